[design/msw_pkg.sv]
// shared types and constants for the stereo mid/side width block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package msw_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int GAIN_FRAC_BITS_DEF = 14;

	localparam int GAIN_W      = 16;
	localparam int EXTRA_BITS  = 16;
	localparam int NOW_W       = GAIN_W + EXTRA_BITS;
	localparam int CFG_INDEX_W = 8;
	localparam int NUM_GAINS   = 3;
	localparam int GAIN_IDX_W  = 2;

	// register indexes, gain targets share their index with the gain slot
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MID   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SIDE  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP  = 8'd3;

	localparam logic [GAIN_IDX_W-1:0] G_WIDTH = 2'd0;
	localparam logic [GAIN_IDX_W-1:0] G_MID   = 2'd1;
	localparam logic [GAIN_IDX_W-1:0] G_SIDE  = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_UNITY  = 16'd16384;
	localparam logic [GAIN_W-1:0] RAMP_RESET  = 16'd2048;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} msw_state_t;

	typedef struct packed {
		logic cfg_we;
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic fin_load;
	} msw_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} msw_sts_t;

endpackage

`default_nettype wire

[design/msw_div.sv]
// radix-2 restoring divider for the ramp step, one quotient bit a cycle
// depends on msw_pkg
`timescale 1ns / 1ps
`default_nettype none

module msw_div
	import msw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NOW_W-1:0]  num_mag,
	input  wire logic              num_neg,
	input  wire logic [GAIN_W-1:0] den,
	output logic                   done,
	output logic [NOW_W-1:0]       quo
);

	localparam int CNT_W = $clog2(NOW_W);

	logic [GAIN_W-1:0] rem_q;
	logic [NOW_W-1:0]  quo_q;
	logic [GAIN_W-1:0] den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [GAIN_W:0]   trial;
	logic [GAIN_W:0]   diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[NOW_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NOW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den;
			neg_q <= num_neg;
		end else if (busy_q) begin
			rem_q <= fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
			quo_q <= {quo_q[NOW_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

[design/msw_gains.sv]
// gain targets, ramp state and per-sample gain advance for width, mid and side
// depends on msw_pkg and msw_div
`timescale 1ns / 1ps
`default_nettype none

module msw_gains
	import msw_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire msw_cmd_t               cmd,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]      cfg_data,
	input  wire logic                   snap,
	output logic                        need_div,
	output logic                        div_done,
	output logic [GAIN_W-1:0]           width_gain,
	output logic [GAIN_W-1:0]           mid_gain,
	output logic [GAIN_W-1:0]           side_gain
);

	logic [GAIN_W-1:0]     tgt_q  [NUM_GAINS];
	logic [NOW_W-1:0]      now_q  [NUM_GAINS];
	logic [NOW_W-1:0]      step_q [NUM_GAINS];
	logic [GAIN_W-1:0]     left_q [NUM_GAINS];
	logic [GAIN_W-1:0]     ramp_q;
	logic [GAIN_IDX_W-1:0] div_sel_q;

	logic                  in_range;
	logic [GAIN_IDX_W-1:0] sel;
	logic [GAIN_W-1:0]     tgt_sel;
	logic [NOW_W-1:0]      now_sel;
	logic                  changed;
	logic [NOW_W:0]        span;
	logic [NOW_W-1:0]      span_mag;
	logic                  div_start;
	logic [NOW_W-1:0]      div_quo;
	logic [NOW_W-1:0]      adv_now [NUM_GAINS];
	logic [NOW_W+1:0]      adv_sum [NUM_GAINS];

	always_comb begin
		in_range = (cfg_index < CFG_INDEX_W'(NUM_GAINS));
		sel      = cfg_index[GAIN_IDX_W-1:0];
		case (sel)
			G_WIDTH: begin
				tgt_sel = tgt_q[G_WIDTH];
				now_sel = now_q[G_WIDTH];
			end
			G_MID: begin
				tgt_sel = tgt_q[G_MID];
				now_sel = now_q[G_MID];
			end
			G_SIDE: begin
				tgt_sel = tgt_q[G_SIDE];
				now_sel = now_q[G_SIDE];
			end
			default: begin
				tgt_sel = '0;
				now_sel = '0;
			end
		endcase
		changed   = in_range && (cfg_data != tgt_sel);
		need_div  = changed && (ramp_q > GAIN_W'(1));
		div_start = cmd.cfg_we && need_div;
		span      = {1'b0, cfg_data, {EXTRA_BITS{1'b0}}} - {1'b0, now_sel};
		span_mag  = span[NOW_W] ? NOW_W'(~span + 1'b1) : span[NOW_W-1:0];
	end

	// ramp advance, clamped to the unsigned range of the current gain
	always_comb begin
		for (int g = 0; g < NUM_GAINS; g++) begin
			adv_sum[g] = {2'b00, now_q[g]} + {{2{step_q[g][NOW_W-1]}}, step_q[g]};
			if (adv_sum[g][NOW_W+1]) begin
				adv_now[g] = '0;
			end else if (adv_sum[g][NOW_W]) begin
				adv_now[g] = '1;
			end else begin
				adv_now[g] = adv_sum[g][NOW_W-1:0];
			end
		end
	end

	msw_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (span_mag),
		.num_neg (span[NOW_W]),
		.den     (ramp_q),
		.done    (div_done),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GAINS; g++) begin
				tgt_q[g]  <= GAIN_UNITY;
				now_q[g]  <= {GAIN_UNITY, {EXTRA_BITS{1'b0}}};
				step_q[g] <= '0;
				left_q[g] <= '0;
			end
			ramp_q    <= RAMP_RESET;
			div_sel_q <= G_WIDTH;
		end else begin
			if (cmd.cfg_we) begin
				if (cfg_index == REG_RAMP) begin
					ramp_q <= cfg_data;
				end else if (changed) begin
					tgt_q[sel] <= cfg_data;
					if (ramp_q == '0) begin
						now_q[sel]  <= {cfg_data, {EXTRA_BITS{1'b0}}};
						left_q[sel] <= '0;
						step_q[sel] <= '0;
					end else begin
						left_q[sel] <= ramp_q;
						if (ramp_q == GAIN_W'(1)) begin
							step_q[sel] <= '0;
						end
					end
				end
			end
			if (div_start) begin
				div_sel_q <= sel;
			end
			if (div_done) begin
				step_q[div_sel_q] <= div_quo;
			end
			if (cmd.load) begin
				for (int g = 0; g < NUM_GAINS; g++) begin
					if (snap) begin
						now_q[g]  <= {tgt_q[g], {EXTRA_BITS{1'b0}}};
						step_q[g] <= '0;
						left_q[g] <= '0;
					end else if (left_q[g] != '0) begin
						left_q[g] <= left_q[g] - 1'b1;
						if (left_q[g] != GAIN_W'(1)) begin
							now_q[g] <= adv_now[g];
						end else begin
							now_q[g] <= {tgt_q[g], {EXTRA_BITS{1'b0}}};
						end
					end
				end
			end
		end
	end

	assign width_gain = now_q[G_WIDTH][NOW_W-1:EXTRA_BITS];
	assign mid_gain   = now_q[G_MID][NOW_W-1:EXTRA_BITS];
	assign side_gain  = now_q[G_SIDE][NOW_W-1:EXTRA_BITS];

endmodule

`default_nettype wire

[design/msw_mac.sv]
// sample datapath: mid/side sums, one shared multiplier, rounding,
// saturation and the output register; depends on msw_pkg
`timescale 1ns / 1ps
`default_nettype none

module msw_mac
	import msw_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire msw_cmd_t                      cmd,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic [GAIN_W-1:0]             width_gain,
	input  wire logic [GAIN_W-1:0]             mid_gain,
	input  wire logic [GAIN_W-1:0]             side_gain,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic                               out_free,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out,
	output logic                               clipped
);

	localparam int SUM_W   = SAMPLE_BITS + 1;
	localparam int MUL_A_W = SUM_W + 18 - GAIN_FRAC_BITS;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = MUL_P_W + 1;
	localparam int RES_W   = ACC_W - GAIN_FRAC_BITS - 1;

	localparam logic signed [MUL_P_W-1:0] HALF1 = MUL_P_W'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0]   HALF2 = ACC_W'(1) << GAIN_FRAC_BITS;
	localparam logic signed [RES_W-1:0]   SAT_HI =
		RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0]   SAT_LO = -SAT_HI - RES_W'(1);

	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SUM_W-1:0]       diff_q;
	logic signed [MUL_A_W-1:0]     side1_q;
	logic signed [MUL_P_W-1:0]     p_q;
	logic signed [MUL_P_W-1:0]     acc_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic                          clip_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic signed [MUL_P_W-1:0] rnd1;
	logic signed [ACC_W-1:0]   lsum;
	logic signed [ACC_W-1:0]   rsum;
	logic signed [RES_W-1:0]   lres;
	logic signed [RES_W-1:0]   rres;
	logic signed [SAMPLE_BITS-1:0] lsat;
	logic signed [SAMPLE_BITS-1:0] rsat;
	logic                      lclip;
	logic                      rclip;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul1) begin
			mul_a = MUL_A_W'(diff_q);
			mul_b = {1'b0, side_gain};
		end else if (cmd.mul2) begin
			mul_a = MUL_A_W'(sum_q);
			mul_b = {1'b0, mid_gain};
		end else if (cmd.mul3) begin
			mul_a = side1_q;
			mul_b = {1'b0, width_gain};
		end
		prod = MUL_P_W'(mul_a * mul_b);
		rnd1 = p_q + HALF1;
	end

	// decode, round half up and saturate
	always_comb begin
		lsum  = ACC_W'(acc_q) + ACC_W'(p_q) + HALF2;
		rsum  = ACC_W'(acc_q) - ACC_W'(p_q) + HALF2;
		lres  = lsum[ACC_W-1:GAIN_FRAC_BITS+1];
		rres  = rsum[ACC_W-1:GAIN_FRAC_BITS+1];
		lclip = (lres > SAT_HI) || (lres < SAT_LO);
		rclip = (rres > SAT_HI) || (rres < SAT_LO);
		if (lres > SAT_HI) begin
			lsat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (lres < SAT_LO) begin
			lsat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			lsat = lres[SAMPLE_BITS-1:0];
		end
		if (rres > SAT_HI) begin
			rsat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rres < SAT_LO) begin
			rsat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			rsat = rres[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q  <= SUM_W'(left_in) + SUM_W'(right_in);
			diff_q <= SUM_W'(left_in) - SUM_W'(right_in);
		end
		if (cmd.mul1 || cmd.mul3) begin
			p_q <= prod;
		end
		if (cmd.mul2) begin
			acc_q   <= prod;
			side1_q <= rnd1[MUL_A_W+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS];
		end
		if (cmd.fin_load) begin
			left_q  <= lsat;
			right_q <= rsat;
			clip_q  <= lclip || rclip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign clipped   = clip_q;

endmodule

`default_nettype wire

[design/msw_ctrl.sv]
// controller: sequences configuration writes, step division and the
// multiply passes of one sample pair; depends on msw_pkg
`timescale 1ns / 1ps
`default_nettype none

module msw_ctrl
	import msw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     cfg_valid,
	input  wire msw_sts_t sts,
	output logic          in_ready,
	output logic          cfg_ready,
	output msw_cmd_t      cmd
);

	msw_state_t st_q;
	msw_state_t st_nxt;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					if (sts.need_div) begin
						st_nxt = ST_DIV;
					end
				end else if (in_valid) begin
					st_nxt = ST_MUL1;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					st_nxt = ST_IDLE;
				end
			end
			ST_MUL1: st_nxt = ST_MUL2;
			ST_MUL2: st_nxt = ST_MUL3;
			ST_MUL3: st_nxt = ST_FIN;
			ST_FIN: begin
				if (sts.out_free) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// configuration requests take priority over sample requests
	always_comb begin
		cfg_ready    = (st_q == ST_IDLE);
		in_ready     = (st_q == ST_IDLE) && !cfg_valid;
		cmd          = '0;
		cmd.cfg_we   = (st_q == ST_IDLE) && cfg_valid;
		cmd.load     = (st_q == ST_IDLE) && !cfg_valid && in_valid;
		cmd.mul1     = (st_q == ST_MUL1);
		cmd.mul2     = (st_q == ST_MUL2);
		cmd.mul3     = (st_q == ST_MUL3);
		cmd.fin_load = (st_q == ST_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	a_no_cfg_with_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cfg_we && cmd.load))
		else $error("configuration write and sample load in one cycle");

	a_div_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && st_nxt == ST_DIV) |-> cmd.cfg_we)
		else $error("division started without a configuration write");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && !sts.out_free) |=> (st_q == ST_FIN && !$past(cmd.fin_load)))
		else $error("result written while output register still full");

endmodule

`default_nettype wire

[design/stereo_mid_side_width.sv]
// Mid/side stereo width processor with linearly ramped gains.
// Sample pairs arrive on the s_axis channel and leave on m_axis, one result
// per request; gains and ramp length are set through the cfg write channel.
// An accepted pair reaches the output register through these steps: the
// accepting cycle loads the sum and difference and advances the gain
// ramps, then come three passes through the single shared multiplier (side
// gain, mid gain, width) and a rounding and saturation step. A new pair
// is taken only after the previous one is written to the output register.
// A write that changes a gain target while the ramp is two samples or more
// starts a step division (one quotient bit a cycle, 32 bits); cfg and s_axis
// requests are held off after the write until the step is stored. Other
// writes need no division.
// The output register holds a finished result while m_axis_tready is low;
// the next pair is accepted and processed meanwhile and waits in the final
// stage until the register is free.
// Reset (arst_n low) sets every gain to unity with no ramp, the ramp length
// to 2048 samples and empties the output register. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stereo_mid_side_width
	import msw_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	localparam int DATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [DATA_W-1:0]      s_axis_tdata,  // left_in, right_in
	input  wire logic                   s_axis_tuser,  // snap_to_target
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [DATA_W-1:0]           m_axis_tdata,  // left_out, right_out
	output logic                        m_axis_tuser,  // clipped
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]      cfg_data
);

	msw_cmd_t cmd;
	msw_sts_t sts;

	logic [GAIN_W-1:0]             width_gain;
	logic [GAIN_W-1:0]             mid_gain;
	logic [GAIN_W-1:0]             side_gain;
	logic                          need_div;
	logic                          div_done;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	always_comb begin
		sts          = '0;
		sts.need_div = need_div;
		sts.div_done = div_done;
		sts.out_free = out_free;
	end

	msw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.in_ready  (s_axis_tready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	msw_gains u_gains (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.snap       (s_axis_tuser),
		.need_div   (need_div),
		.div_done   (div_done),
		.width_gain (width_gain),
		.mid_gain   (mid_gain),
		.side_gain  (side_gain)
	);

	msw_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.left_in    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.right_in   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.width_gain (width_gain),
		.mid_gain   (mid_gain),
		.side_gain  (side_gain),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_free   (out_free),
		.left_out   (left_out),
		.right_out  (right_out),
		.clipped    (m_axis_tuser)
	);

	assign m_axis_tdata = DATA_W'({right_out, left_out});

endmodule

`default_nettype wire
